@@ hdl/mi4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg
// widths, sequencer states and index helpers for the 4x4 cofactor inverse
// ----------------------------------------------------------------------------
package mi4_pkg;

  // element format: signed, ElemWidth bits with FracBits fraction bits
  localparam int ElemWidth = 15;
  localparam int FracBits  = 10;

  localparam int EW  = ElemWidth;
  localparam int PW  = 2 * EW + 1;            // 2x2 minor
  localparam int CW  = 3 * EW + 1;            // cofactor
  localparam int DW  = 4 * EW + 1;            // determinant
  localparam int MBW = PW;                    // multiplier b operand
  localparam int MPW = EW + MBW;              // multiplier product
  localparam int LW  = CW / 2;                // low half of a cofactor
  localparam int HW  = CW - LW;               // high half of a cofactor
  localparam int QW  = EW + 1;                // quotient bits kept
  localparam int NW  = CW + 2 * FracBits;     // scaled dividend
  localparam int TW  = NW - QW;               // dividend bits above quotient
  localparam int XW  = (TW > DW + 1) ? TW : DW + 1;  // partial remainder
  localparam int DCW = $clog2(QW + 1);

  typedef logic [EW-1:0] elem_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COF    = 7'b0000010,
    S_DET    = 7'b0000100,
    S_DMAG   = 7'b0001000,
    S_DIVSET = 7'b0010000,
    S_DIVRUN = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_e;

  // k-th surviving index once index del is removed
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] del);
    logic [1:0] r;
    r = (k >= del) ? k + 2'd1 : k;
    return r;
  endfunction

endpackage

@@ hdl/matrix_inverse_4x4_unit.sv @@
// order: all 16 cofactors, then the determinant, its magnitude, then one bit-serial
//   division per element to the last result word; a singular matrix skips division
// loads take one word a cycle while idle; from go the input stalls to the last word
// all cofactor and determinant work runs through one 15 x 31 bit multiplier
// reset: async active low, clears the sequencer and output valid; stores undefined
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit
// 4x4 fixed point inverse by cofactors with one shared multiplier and a
// bit-serial restoring divider
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [3:0]           element_index_i,
  input  logic signed [mi4_pkg::EW-1:0] element_value_i,
  input  logic                 go_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           result_index_o,
  output logic signed [mi4_pkg::EW-1:0] result_value_o,
  output logic                 invertible_o,
  output logic                 saturated_o,
  output logic                 last_o
);
  import mi4_pkg::*;

  // matrix store column-major {col, row}; cofactor store row-major {row, col}
  logic signed [EW-1:0] mat_q [16];
  logic signed [CW-1:0] cof_q [16];

  state_e state_q, state_d;

  // sequencer counters
  logic [3:0] idx_q;     // cofactor index, determinant row, output index
  logic [1:0] term_q;    // term of the 3x3 expansion
  logic [2:0] micro_q;   // micro step
  logic [DCW-1:0] dcnt_q;

  // datapath
  logic signed [EW-1:0]  opa_q;
  logic signed [MPW-1:0] prod_q;
  logic signed [PW-1:0]  minor_q;
  logic signed [CW-1:0]  acc_q;
  logic signed [DW-1:0]  det_q;
  logic [DW-1:0]         dmag_q;
  logic [XW-1:0]         rem_q;
  logic [QW-1:0]         quo_q;
  logic                  neg_q, ovf_q, sing_q;

  // output word register
  logic                  out_valid_q;
  logic [3:0]            res_idx_q;
  logic [EW-1:0]         res_val_q;
  logic                  res_inv_q, res_sat_q, res_last_q;

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // minor index selection for the current cofactor and term
  logic [1:0] dr, dc, cl, ch, rd_row, rd_col;
  logic [3:0] rd_addr;
  logic signed [EW-1:0] rd_val;

  always_comb begin
    dr = idx_q[3:2];
    dc = idx_q[1:0];
    cl = (term_q == 2'd0) ? 2'd1 : 2'd0;
    ch = (term_q == 2'd2) ? 2'd1 : 2'd2;
    case (micro_q)
      3'd0: begin
        rd_row = skip_idx(2'd1, dr);
        rd_col = skip_idx(cl, dc);
      end
      3'd1: begin
        rd_row = skip_idx(2'd2, dr);
        rd_col = skip_idx(ch, dc);
      end
      3'd2: begin
        rd_row = skip_idx(2'd1, dr);
        rd_col = skip_idx(ch, dc);
      end
      3'd3: begin
        rd_row = skip_idx(2'd2, dr);
        rd_col = skip_idx(cl, dc);
      end
      default: begin
        rd_row = skip_idx(2'd0, dr);
        rd_col = skip_idx(term_q, dc);
      end
    endcase
    // determinant walks the first column
    if (state_q == S_DET) rd_addr = {2'b00, idx_q[1:0]};
    else rd_addr = {rd_col, rd_row};
  end

  assign rd_val = mat_q[rd_addr];

  // one cofactor read port: first column during determinant, else output index
  logic [3:0] cof_addr;
  logic signed [CW-1:0] cof_rd;
  assign cof_addr = (state_q == S_DET) ? {idx_q[1:0], 2'b00} : idx_q;
  assign cof_rd   = cof_q[cof_addr];

  // shared multiplier
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;

  always_comb begin
    if (state_q == S_DET) begin
      if (micro_q == 3'd1) mul_b = {{(MBW-LW){1'b0}}, cof_rd[LW-1:0]};
      else mul_b = {{(MBW-HW){cof_rd[CW-1]}}, cof_rd[CW-1:LW]};
    end else if (micro_q == 3'd5) begin
      mul_b = minor_q;
    end else begin
      mul_b = {{(MBW-EW){rd_val[EW-1]}}, rd_val};
    end
  end

  assign mul_p = opa_q * mul_b;

  // cofactor accumulation
  logic signed [CW-1:0] prod_c, acc_sum, cof_val;
  assign prod_c  = prod_q[CW-1:0];
  assign acc_sum = ((term_q == 2'd0) ? CW'(0) : acc_q)
                 + ((term_q == 2'd1) ? -prod_c : prod_c);
  assign cof_val = (idx_q[2] ^ idx_q[0]) ? -acc_sum : acc_sum;

  // determinant partial products, sign extended
  logic signed [DW-1:0] prod_ext;
  assign prod_ext = {{(DW-MPW){prod_q[MPW-1]}}, prod_q};

  // divider setup
  logic [CW-1:0] nmag;
  logic [NW-1:0] nscaled;
  logic [TW-1:0] ntop;
  logic          ovf_c;
  assign nmag    = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
  assign nscaled = {nmag, {(2 * FracBits){1'b0}}};
  assign ntop    = nscaled[NW-1:QW];
  assign ovf_c   = XW'(ntop) >= XW'(dmag_q);

  // one restoring step
  logic [XW-1:0] trial;
  logic          ge;
  assign trial = {rem_q[XW-2:0], quo_q[QW-1]};
  assign ge    = trial >= XW'(dmag_q);

  // final saturation
  logic [QW-1:0] limit, qsat;
  logic          sat_c;
  logic [EW-1:0] val_c;
  assign limit = neg_q ? (QW'(1) << (EW - 1)) : ((QW'(1) << (EW - 1)) - QW'(1));
  assign sat_c = ovf_q || (quo_q > limit);
  assign qsat  = sat_c ? limit : quo_q;
  assign val_c = neg_q ? EW'(-qsat) : EW'(qsat);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // output valid: held while stalled, set when a word is loaded
  logic out_valid_d;
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == S_EMIT && out_free) out_valid_d = 1'b1;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc && go_i) state_d = S_COF;
      S_COF:    if (micro_q == 3'd6 && term_q == 2'd2 && idx_q == 4'd15) state_d = S_DET;
      S_DET:    if (micro_q == 3'd3 && idx_q[1:0] == 2'd3) state_d = S_DMAG;
      S_DMAG:   state_d = (det_q == '0) ? S_EMIT : S_DIVSET;
      S_DIVSET: state_d = ovf_c ? S_EMIT : S_DIVRUN;
      S_DIVRUN: if (dcnt_q == DCW'(QW - 1)) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = (sing_q || idx_q == 4'd15) ? S_IDLE : S_DIVSET;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      term_q      <= '0;
      micro_q     <= '0;
      dcnt_q      <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          idx_q   <= '0;
          term_q  <= '0;
          micro_q <= '0;
          sing_q  <= 1'b0;
        end
        S_COF: begin
          if (micro_q == 3'd6) begin
            micro_q <= '0;
            if (term_q == 2'd2) begin
              term_q <= '0;
              idx_q  <= idx_q + 4'd1;
            end else begin
              term_q <= term_q + 2'd1;
            end
          end else begin
            micro_q <= micro_q + 3'd1;
          end
        end
        S_DET: begin
          if (micro_q == 3'd3) begin
            micro_q <= '0;
            idx_q   <= (idx_q[1:0] == 2'd3) ? 4'd0 : idx_q + 4'd1;
          end else begin
            micro_q <= micro_q + 3'd1;
          end
        end
        S_DMAG: sing_q <= (det_q == '0);
        S_DIVSET: dcnt_q <= '0;
        S_DIVRUN: dcnt_q <= dcnt_q + DCW'(1);
        S_EMIT: begin
          if (out_free) idx_q <= idx_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath and stores, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) mat_q[element_index_i] <= element_value_i;
    case (state_q)
      S_COF: begin
        case (micro_q)
          3'd0: opa_q <= rd_val;
          3'd1: prod_q <= mul_p;
          3'd2: begin
            minor_q <= prod_q[PW-1:0];
            opa_q   <= rd_val;
          end
          3'd3: prod_q <= mul_p;
          3'd4: begin
            minor_q <= minor_q - prod_q[PW-1:0];
            opa_q   <= rd_val;
          end
          3'd5: prod_q <= mul_p;
          default: begin
            acc_q <= acc_sum;
            if (term_q == 2'd2) cof_q[idx_q] <= cof_val;
            det_q <= '0;
          end
        endcase
      end
      S_DET: begin
        case (micro_q)
          3'd0: opa_q <= rd_val;
          3'd1: prod_q <= mul_p;
          3'd2: begin
            det_q  <= det_q + prod_ext;
            prod_q <= mul_p;
          end
          default: det_q <= det_q + (prod_ext <<< LW);
        endcase
      end
      S_DMAG: dmag_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      S_DIVSET: begin
        neg_q <= cof_rd[CW-1] ^ det_q[DW-1];
        ovf_q <= ovf_c;
        rem_q <= XW'(ntop);
        quo_q <= nscaled[QW-1:0];
      end
      S_DIVRUN: begin
        rem_q <= ge ? trial - XW'(dmag_q) : trial;
        quo_q <= {quo_q[QW-2:0], ge};
      end
      S_EMIT: begin
        if (out_free) begin
          if (sing_q) begin
            res_idx_q  <= '0;
            res_val_q  <= '0;
            res_inv_q  <= 1'b0;
            res_sat_q  <= 1'b0;
            res_last_q <= 1'b1;
          end else begin
            res_idx_q  <= idx_q;
            res_val_q  <= val_c;
            res_inv_q  <= 1'b1;
            res_sat_q  <= sat_c;
            res_last_q <= (idx_q == 4'd15);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_index_o = res_idx_q;
  assign result_value_o = res_val_q;
  assign invertible_o   = res_inv_q;
  assign saturated_o    = res_sat_q;
  assign last_o         = res_last_q;

`ifndef NO_ASSERTIONS
  // a singular word is a lone zero word that closes the run
  a_singular_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invertible_o |-> last_o && !saturated_o && result_value_o == '0)
    else $error("singular word malformed");

  // go starts the cofactor pass on the next cycle
  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && go_i |=> state_q == S_COF)
    else $error("go did not start inversion");

  // the divider only runs against a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVSET |-> dmag_q != '0)
    else $error("divide by zero determinant");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVRUN |-> rem_q < XW'(dmag_q))
    else $error("remainder out of range");
`endif

endmodule
